>>> rtl/esc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the email structure checker.
// No dependencies; esc_judge and the top level import this package.
package esc_pkg;

  // Widths of the configuration port.
  localparam int unsigned RegW    = 10;
  localparam int unsigned CfgIdxW = 2;

  // Default width of the saturating string counters.
  localparam int unsigned CountBitsDef = 10;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] RegMinLength = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxLength = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLocalMax  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegDomainMax = 2'd3;

  // Register reset values.
  localparam logic [RegW-1:0] MinLengthRst = 10'd3;
  localparam logic [RegW-1:0] MaxLengthRst = 10'd254;
  localparam logic [RegW-1:0] LocalMaxRst  = 10'd64;
  localparam logic [RegW-1:0] DomainMaxRst = 10'd253;

  // Bytes of interest.
  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChNul = 8'h00;
  localparam logic [7:0] ChAt  = 8'h40;
  localparam logic [7:0] ChDot = 8'h2E;

  // Reject reasons, in check order.
  typedef enum logic [2:0] {
    ReasonOk        = 3'd0,
    ReasonTotalLen  = 3'd1,
    ReasonBadChar   = 3'd2,
    ReasonNoAt      = 3'd3,
    ReasonLocalLen  = 3'd4,
    ReasonDomainLen = 3'd5,
    ReasonDot       = 3'd6
  } esc_reason_e;

  // Configuration register set.
  typedef struct packed {
    logic [RegW-1:0] min_length;
    logic [RegW-1:0] max_length;
    logic [RegW-1:0] local_max;
    logic [RegW-1:0] domain_max;
  } esc_cfg_t;

  // Per-string flags.
  typedef struct packed {
    logic bad_char;
    logic at_seen;
    logic dot_seen;
  } esc_flags_t;

endpackage

>>> rtl/esc_char_if.sv
`timescale 1ns / 1ps
// Input channel: one address byte per word with a last-byte flag.
// No dependencies.
interface esc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_last;

  modport source (output valid, output char_byte, output is_last, input ready);
  modport sink   (input valid, input char_byte, input is_last, output ready);
endinterface

>>> rtl/esc_res_if.sv
`timescale 1ns / 1ps
// Result channel: pass flag and reject reason, one word per string.
// No dependencies.
interface esc_res_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic [2:0] reject_reason;

  modport source (output valid, output valid_res, output reject_reason, input ready);
  modport sink   (input valid, input valid_res, input reject_reason, output ready);
endinterface

>>> rtl/esc_judge.sv
`timescale 1ns / 1ps
// Ordered structural checks on the final counts of one string.
// Depends on esc_pkg.
module esc_judge #(
  parameter int unsigned COUNT_BITS = esc_pkg::CountBitsDef
) (
  input  esc_pkg::esc_cfg_t    cfg_i,
  input  esc_pkg::esc_flags_t  flags_i,
  input  logic [COUNT_BITS-1:0] total_i,
  input  logic [COUNT_BITS-1:0] local_i,
  input  logic [COUNT_BITS-1:0] domain_i,
  input  logic [COUNT_BITS-1:0] dot_pos_i,
  output esc_pkg::esc_reason_e reason_o
);
  import esc_pkg::*;

  // Common width for comparing counters against registers.
  localparam int unsigned CmpW = (COUNT_BITS > RegW) ? COUNT_BITS : RegW;

  logic [CmpW-1:0]       total_w;
  logic [CmpW-1:0]       local_w;
  logic [CmpW-1:0]       domain_w;
  logic [COUNT_BITS-1:0] domain_m1;

  assign total_w   = CmpW'(total_i);
  assign local_w   = CmpW'(local_i);
  assign domain_w  = CmpW'(domain_i);
  assign domain_m1 = domain_i - COUNT_BITS'(1);

  // The first failing check sets the reason.
  always_comb begin
    if (total_w < CmpW'(cfg_i.min_length) || total_w > CmpW'(cfg_i.max_length)) begin
      reason_o = ReasonTotalLen;
    end else if (flags_i.bad_char) begin
      reason_o = ReasonBadChar;
    end else if (!flags_i.at_seen) begin
      reason_o = ReasonNoAt;
    end else if (local_i == '0 || local_w > CmpW'(cfg_i.local_max)) begin
      reason_o = ReasonLocalLen;
    end else if (domain_i == '0 || domain_w > CmpW'(cfg_i.domain_max)) begin
      reason_o = ReasonDomainLen;
    end else if (!flags_i.dot_seen || dot_pos_i == '0 || dot_pos_i == domain_m1) begin
      reason_o = ReasonDot;
    end else begin
      reason_o = ReasonOk;
    end
  end

endmodule

>>> rtl/email_structure_checker_core.sv
`timescale 1ns / 1ps
// Email address structure checker, top level.
// Depends on esc_pkg, esc_char_if, esc_res_if and esc_judge.
//
//   Port     Direction  Word                           Handshake
//   char_i   in         char_byte[7:0], is_last        valid/ready
//   res_o    out        valid_res, reject_reason[2:0]  valid/ready
//   cfg_*    in         cfg_idx_i, cfg_data_i[9:0]     cfg_we_i, no wait
//
// One byte is accepted every cycle while the input register is not stalled.
// The byte is held in an input register; from there it updates the string
// counters and, on the last byte, loads the result register. Reset clears the
// counters and loads the register defaults; no sweep is needed. Only a last
// byte can stall, in the input register, while the result register holds a
// word that the sink has not taken.
module email_structure_checker_core #(
  parameter int unsigned COUNT_BITS = esc_pkg::CountBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [esc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [esc_pkg::RegW-1:0]    cfg_data_i,
  esc_char_if.sink                   char_i,
  esc_res_if.source                  res_o
);
  import esc_pkg::*;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  esc_cfg_t              cfg_q;
  logic                  s1_vld_q;
  logic [7:0]            s1_byte_q;
  logic                  s1_last_q;
  logic                  s1_fire;
  logic                  out_free;

  esc_flags_t            flags_q, flags_d;
  logic [COUNT_BITS-1:0] total_q, total_d;
  logic [COUNT_BITS-1:0] local_q, local_d;
  logic [COUNT_BITS-1:0] domain_q, domain_d;
  logic [COUNT_BITS-1:0] dot_pos_q, dot_pos_d;

  esc_reason_e           reason;
  logic                  out_vld_q;
  logic                  out_pass_q;
  logic [2:0]            out_reason_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_length <= MinLengthRst;
      cfg_q.max_length <= MaxLengthRst;
      cfg_q.local_max  <= LocalMaxRst;
      cfg_q.domain_max <= DomainMaxRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMinLength: cfg_q.min_length <= cfg_data_i;
        RegMaxLength: cfg_q.max_length <= cfg_data_i;
        RegLocalMax:  cfg_q.local_max  <= cfg_data_i;
        RegDomainMax: cfg_q.domain_max <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: a non-last byte always moves on, a last byte needs a free result slot.
  assign out_free     = !out_vld_q || res_o.ready;
  assign s1_fire      = s1_vld_q && (!s1_last_q || out_free);
  assign char_i.ready = !s1_vld_q || s1_fire;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (char_i.valid && char_i.ready) begin
      s1_vld_q <= 1'b1;
    end else if (s1_fire) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      s1_byte_q <= char_i.char_byte;
      s1_last_q <= char_i.is_last;
    end
  end

  // Counter and flag updates for the byte in the input register.
  always_comb begin
    flags_d   = flags_q;
    local_d   = local_q;
    domain_d  = domain_q;
    dot_pos_d = dot_pos_q;
    total_d   = sat_inc(total_q);
    if (s1_byte_q == ChCr || s1_byte_q == ChLf || s1_byte_q == ChNul) begin
      flags_d.bad_char = 1'b1;
    end
    if (!flags_q.at_seen) begin
      if (s1_byte_q == ChAt) begin
        flags_d.at_seen = 1'b1;
        local_d         = total_q;
      end
    end else begin
      if (s1_byte_q == ChDot && !flags_q.dot_seen) begin
        flags_d.dot_seen = 1'b1;
        dot_pos_d        = domain_q;
      end
      domain_d = sat_inc(domain_q);
    end
  end

  // Per-string state, cleared after each last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q   <= '0;
      total_q   <= '0;
      local_q   <= '0;
      domain_q  <= '0;
      dot_pos_q <= '0;
    end else if (s1_fire) begin
      if (s1_last_q) begin
        flags_q   <= '0;
        total_q   <= '0;
        local_q   <= '0;
        domain_q  <= '0;
        dot_pos_q <= '0;
      end else begin
        flags_q   <= flags_d;
        total_q   <= total_d;
        local_q   <= local_d;
        domain_q  <= domain_d;
        dot_pos_q <= dot_pos_d;
      end
    end
  end

  // Checks on the counts including the last byte.
  esc_judge #(
    .COUNT_BITS (COUNT_BITS)
  ) u_judge (
    .cfg_i     (cfg_q),
    .flags_i   (flags_d),
    .total_i   (total_d),
    .local_i   (local_d),
    .domain_i  (domain_d),
    .dot_pos_i (dot_pos_d),
    .reason_o  (reason)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_fire && s1_last_q) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      out_pass_q   <= (reason == ReasonOk);
      out_reason_q <= 3'(reason);
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.valid_res     = out_pass_q;
  assign res_o.reject_reason = out_reason_q;

`ifndef ASSERT_OFF
  // A last byte that moves on always leaves a result behind.
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_last_q) |=> out_vld_q)
    else $error("last byte did not load a result");

  // A last byte clears the string state.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_last_q) |=> (total_q == '0 && !flags_q.at_seen && !flags_q.dot_seen))
    else $error("string state not cleared after last byte");

  // Pass flag agrees with the reason code.
  a_pass_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_pass_q == (out_reason_q == 3'(ReasonOk))))
    else $error("pass flag disagrees with reason");

  // Domain counters stay clear until the first at sign.
  a_domain_after_at: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !flags_q.at_seen |-> (domain_q == '0 && local_q == '0 && !flags_q.dot_seen))
    else $error("domain state moved before at sign");

  // An empty input register always takes a byte.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_vld_q |-> char_i.ready)
    else $error("input stalled while empty");
`endif

endmodule
